### design/pas_pkg.sv
// package for the polyline angle simplifier: payload types, constants
// no dependencies
`default_nettype none
package pas_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordW = 16;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               end_of_line;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               final_point;
    logic               overflowed;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pt_t;

  // front to back queue word
  typedef struct packed {
    pt_t  pt;
    logic eol;
  } q_word_t;
endpackage
`default_nettype wire

### design/pas_front.sv
// input front: registers accepted words into a two entry queue
// depends on pas_pkg
`default_nettype none
module pas_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pas_pkg::in_item_t in_data,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output pas_pkg::q_word_t      q_word
);
  import pas_pkg::*;
  q_word_t mem_r [2];
  logic [1:0] wp_r, rp_r;
  logic [1:0] wp_nxt, rp_nxt;
  logic       push, pop;

  assign in_ready = (wp_r - rp_r) != 2'd2;
  assign q_valid  = wp_r != rp_r;
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_word   = mem_r[rp_r[0]];
  assign wp_nxt   = wp_r + {1'b0, push};
  assign rp_nxt   = rp_r + {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r[0]] <= '{pt: '{in_data.coord_x, in_data.coord_y, in_data.coord_z},
                          eol: in_data.end_of_line};
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end
endmodule
`default_nettype wire

### design/pas_back.sv
// back end: point store, simplify passes with a staged cosine test, emit
// depends on pas_pkg
`default_nettype none
module pas_back #(
  parameter int unsigned MAX_POINTS = pas_pkg::MaxPointsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic signed [15:0] thr,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire pas_pkg::q_word_t   q_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pas_pkg::out_item_t      out_data
);
  import pas_pkg::*;
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CapC = CW'(MAX_POINTS);

  localparam logic [3:0] S_LOAD = 4'd0, S_RD0 = 4'd1, S_RD1 = 4'd2, S_RD2 = 4'd3,
                         S_M1 = 4'd4, S_M2 = 4'd5, S_M3 = 4'd6, S_M4 = 4'd7,
                         S_DEC = 4'd8, S_MV = 4'd9, S_PASS = 4'd10, S_ER = 4'd11,
                         S_EW = 4'd12, S_CMP = 4'd13;

  pt_t mem_r [MAX_POINTS];
  pt_t rd_r, a_r, b_r, c_r;
  logic [3:0] st_r;
  logic [CW-1:0] n_r, i_r, j_r;
  logic ovf_r, rem_r, last_r;
  logic [AW-1:0] ra;
  logic signed [17:0] cx, cy, cz, gx, gy, gz;
  logic [35:0] lc_r, lg_r;
  logic signed [37:0] dot_r;
  logic [71:0] ad2_r;
  logic [67:0] lcg_r;
  logic [31:0] at2_r;
  logic [65:0] rp0_r, rp1_r;
  logic [103:0] lhs_r, rhs_r;
  logic [37:0] ad;
  logic [15:0] at;
  logic [18:0] ad_hi, ad_lo;
  logic [17:0] lc_hi, lc_lo;
  logic [37:0] pa_hh, pa_hl, pa_ll;
  logic [53:0] pl_h, pl_l;
  logic keep_r, take, strt;

  assign q_ready = st_r == S_LOAD;
  assign take = q_valid && q_ready;
  assign cx = 18'(b_r.x) - 18'(a_r.x); assign gx = 18'(c_r.x) - 18'(b_r.x);
  assign cy = 18'(b_r.y) - 18'(a_r.y); assign gy = 18'(c_r.y) - 18'(b_r.y);
  assign cz = 18'(b_r.z) - 18'(a_r.z); assign gz = 18'(c_r.z) - 18'(b_r.z);
  assign ad = dot_r[37] ? 38'(-dot_r) : 38'(dot_r);
  assign at = thr[15] ? 16'(-thr) : 16'(thr);

  // split the |dot| and |c|^2 operands into high and low halves to narrow the products
  assign ad_hi = ad[37:19];
  assign ad_lo = ad[18:0];
  assign lc_hi = lc_r[35:18];
  assign lc_lo = lc_r[17:0];
  assign pa_hh = ad_hi * ad_hi;
  assign pa_hl = ad_hi * ad_lo;
  assign pa_ll = ad_lo * ad_lo;
  assign pl_h  = lc_hi * lg_r;
  assign pl_l  = lc_lo * lg_r;

  // read address per state
  always_comb begin
    case (st_r)
      S_RD0:   ra = AW'(i_r - 1'b1);
      S_RD1:   ra = AW'(i_r);
      S_RD2:   ra = AW'(i_r + 1'b1);
      S_MV:    ra = AW'(j_r + 1'b1);
      default: ra = AW'(j_r);
    endcase
  end

  // straightness decision from staged products
  always_comb begin
    if (lc_r == '0 || lg_r == '0)        strt = 1'b0;
    else if (!thr[15] && (dot_r <= 0))  strt = 1'b0;
    else if (thr[15] && (dot_r >= 0))   strt = 1'b1;
    else if (!thr[15])                  strt = lhs_r > rhs_r;
    else                                strt = lhs_r < rhs_r;
  end

  always_ff @(posedge clk) begin
    rd_r <= mem_r[ra];
    if (take && n_r < CapC) mem_r[AW'(n_r)] <= q_word.pt;
    if (st_r == S_MV && j_r + 1'b1 < n_r) mem_r[AW'(j_r)] <= rd_r;
    case (st_r)
      S_CMP: begin
        lc_r  <= 36'(cx*cx) + 36'(cy*cy) + 36'(cz*cz);
        lg_r  <= 36'(gx*gx) + 36'(gy*gy) + 36'(gz*gz);
        dot_r <= 38'(cx*gx) + 38'(cy*gy) + 38'(cz*gz);
      end
      S_M2: begin
        ad2_r <= ({34'd0, pa_hh} << 38) + ({34'd0, pa_hl} << 20) + {34'd0, pa_ll};
        at2_r <= 32'(at) * 32'(at);
        lcg_r <= 68'(({18'd0, pl_h} << 18) + {18'd0, pl_l});
      end
      S_M3: begin
        lhs_r <= {2'b00, ad2_r, 30'd0};
        rp0_r <= lcg_r[33:0] * at2_r;
        rp1_r <= lcg_r[67:34] * at2_r;
      end
      S_M4: begin
        rhs_r <= 104'(rp0_r) + (104'(rp1_r) << 34);
      end
      default: ;
    endcase
    if (!rst_n) begin
      st_r <= S_LOAD; n_r <= '0; ovf_r <= 1'b0; out_valid <= 1'b0;
      i_r <= '0; j_r <= '0; rem_r <= 1'b0; keep_r <= 1'b0; last_r <= 1'b0;
    end else begin
      case (st_r)
        S_LOAD: if (take) begin
          if (n_r < CapC) n_r <= n_r + 1'b1;
          else ovf_r <= 1'b1;
          if (q_word.eol) begin
            i_r <= CW'(1); rem_r <= 1'b0;
            st_r <= ((n_r < CapC ? n_r + 1'b1 : n_r) < CW'(4)) ? S_ER : S_PASS;
            j_r <= '0;
          end
        end
        S_PASS: begin
          if (32'(i_r) + 2 < 32'(n_r)) st_r <= S_RD0;
          else if (rem_r) begin i_r <= CW'(1); rem_r <= 1'b0; end
          else begin j_r <= '0; st_r <= S_ER; end
        end
        S_RD0: st_r <= S_RD1;
        S_RD1: begin a_r <= rd_r; st_r <= S_RD2; end
        S_RD2: begin b_r <= rd_r; st_r <= S_M1; end
        S_M1:  begin c_r <= rd_r; st_r <= S_CMP; end
        S_CMP: st_r <= S_M2;
        S_M2:  st_r <= S_M3;
        S_M3:  st_r <= S_M4;
        S_M4:  st_r <= S_DEC;
        S_DEC: if (strt) begin
          j_r <= i_r; rem_r <= 1'b1; st_r <= S_MV;
        end else begin
          i_r <= i_r + 1'b1; st_r <= S_PASS;
        end
        S_MV: begin
          // rd_r holds entry j+1 in the cycle after its address; j steps only when keep_r is set
          keep_r <= ~keep_r;
          if (keep_r) begin
            if (j_r + 1'b1 < n_r) j_r <= j_r + 1'b1;
            else begin n_r <= n_r - 1'b1; i_r <= i_r + CW'(2); st_r <= S_PASS; end
          end
        end
        S_ER: begin last_r <= (j_r + 1'b1 == n_r); st_r <= S_EW; end
        S_EW: if (!out_valid || out_ready) begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data <= '{rd_r.x, rd_r.y, rd_r.z, last_r, ovf_r};
          end else begin
            out_valid <= 1'b0;
            if (out_data.final_point) begin
              n_r <= '0; ovf_r <= 1'b0; st_r <= S_LOAD;
            end else begin j_r <= j_r + 1'b1; st_r <= S_ER; end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/polyline_angle_simplifier_unit.sv
// top level of the polyline angle simplifier: threshold register, front, back
// depends on pas_pkg, pas_front, pas_back
// load: one word a cycle through a two word queue while the back end is loading
// simplify: three reads and a staged cosine test per tested interior point; a removal
// shifts later entries down; passes repeat until no removal; worst case order n^2 tests
// emit: one kept point at a time through the output register, held while out_ready is low
// reset (rst_n low, synchronous) empties the store and sets the threshold to 32767
`default_nettype none
module polyline_angle_simplifier_unit #(
  parameter int unsigned MAX_POINTS = pas_pkg::MaxPointsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pas_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pas_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic signed [15:0] cfg_cos_threshold
);
  import pas_pkg::*;
  logic signed [15:0] thr_r;
  logic    q_valid, q_ready;
  q_word_t q_word;

  // cosine threshold, Q1.15
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 16'sd32767;
    else if (cfg_we) thr_r <= cfg_cos_threshold;
  end

  // front queues accepted words
  pas_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_word
  );

  // back stores, simplifies and emits
  pas_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst_n, .thr(thr_r), .q_valid, .q_ready, .q_word,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

### design/pas_checker.sv
// port checker for the polyline angle simplifier
// depends on pas_pkg, bound to polyline_angle_simplifier_unit
`default_nettype none
module pas_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire pas_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.final_point ##1 out_valid
    |-> out_data.overflowed == $past(out_data.overflowed)) else $error("ovf");
endmodule
bind polyline_angle_simplifier_unit pas_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);
`default_nettype wire
